FILE: rtl/aort_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aort_pkg
// Shared types and constants for the auto-off relay timer.
// ----------------------------------------------------------------------------
package aort_pkg;

  localparam int REG_W          = 27;
  localparam int COUNT_BITS_DEF = 27;
  localparam int CFG_IDX_W      = 3;
  localparam int SECS_W         = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP      = 3'd0,
    REG_MAX_ON    = 3'd1,
    REG_WARN      = 3'd2,
    REG_OFF_DELAY = 3'd3
  } reg_idx_t;

  localparam logic [REG_W-1:0] STEP_RST      = 27'd1800000;
  localparam logic [REG_W-1:0] MAX_ON_RST    = 27'd18000000;
  localparam logic [REG_W-1:0] WARN_RST      = 27'd120000;
  localparam logic [REG_W-1:0] OFF_DELAY_RST = 27'd6000;

  // warn to off-delayed and off-delayed to off limits, ms
  localparam int WARN_END_MS = 1000;
  localparam int OFF_END_MS  = 100;

  // largest ms value kept for the seconds display (131071 s saturation)
  localparam logic [REG_W-1:0] SEC_CLIP_MS = 27'd131071999;

  // ms / 1000 as (ms >> 3) / 125, reciprocal exact for 24-bit operands
  localparam int               DIV_PRE_SHIFT = 3;
  localparam int               DIV_IN_W      = REG_W - DIV_PRE_SHIFT;
  localparam int               RECIP_W       = 28;
  localparam logic [RECIP_W-1:0] RECIP_125   = 28'd137438954;
  localparam int               RECIP_SHIFT   = 34;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_ON     = 2'd1,
    MODE_WARN   = 2'd2,
    MODE_OFFDLY = 2'd3
  } mode_t;

  typedef struct packed {
    logic green_press;
    logic red_press;
  } in_item_t;

  typedef struct packed {
    logic              relay_on;
    logic [1:0]        mode;
    logic [SECS_W-1:0] seconds_left;
    logic              mode_changed;
  } out_item_t;

  typedef struct packed {
    logic [REG_W-1:0] step_ms;
    logic [REG_W-1:0] on_cap_ms;
    logic [REG_W-1:0] warn_ms;
    logic [REG_W-1:0] grace_ms;
  } cfg_t;

  typedef struct packed {
    mode_t            mode;
    logic             mode_changed;
    logic [REG_W-1:0] ms_clip;
  } s1_t;

endpackage

FILE: rtl/aort_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aort_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module aort_cfg
  import aort_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_ms   <= STEP_RST;
      cfg_r.on_cap_ms <= MAX_ON_RST;
      cfg_r.warn_ms   <= WARN_RST;
      cfg_r.grace_ms  <= OFF_DELAY_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_STEP:      cfg_r.step_ms   <= cfg_data;
        REG_MAX_ON:    cfg_r.on_cap_ms <= cfg_data;
        REG_WARN:      cfg_r.warn_ms   <= cfg_data;
        REG_OFF_DELAY: cfg_r.grace_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/aort_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aort_step
// Per-tick mode and countdown update, with the first pipeline register.
// ----------------------------------------------------------------------------
module aort_step
  import aort_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_valid,
  input  in_item_t in_data,
  output logic     in_ready,
  input  logic     dn_ready,
  output logic     s1_valid,
  output s1_t      s1_data
);

  localparam int W = ((COUNT_BITS > REG_W) ? COUNT_BITS : REG_W) + 1;
  localparam logic [COUNT_BITS-1:0] CMAX   = {COUNT_BITS{1'b1}};
  localparam logic [W-1:0]          CMAX_W = W'(CMAX);

  function automatic logic [COUNT_BITS-1:0] sat_cnt(input logic [W-1:0] v);
    return (v > CMAX_W) ? CMAX : v[COUNT_BITS-1:0];
  endfunction

  mode_t                 mode_r, mode_btn, mode_nxt;
  logic [COUNT_BITS-1:0] rem_r, rem_dec, rem_btn, rem_nxt;
  logic [COUNT_BITS-1:0] load_off, load_step;
  logic [W-1:0]          sum, capped;
  logic                  s1_v_r;
  s1_t                   s1_r, s1_nxt;
  logic                  in_fire;

  assign in_ready = !s1_v_r || dn_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    rem_dec   = (rem_r != '0) ? rem_r - COUNT_BITS'(1) : '0;
    load_off  = sat_cnt(W'(cfg.grace_ms));
    load_step = sat_cnt(W'(cfg.step_ms));
    sum       = W'(rem_dec) + W'(cfg.step_ms);
    capped    = (sum > W'(cfg.on_cap_ms)) ? W'(cfg.on_cap_ms) : sum;

    // buttons, red first
    mode_btn = mode_r;
    rem_btn  = rem_dec;
    if (in_data.red_press && mode_r != MODE_OFF) begin
      mode_btn = MODE_OFFDLY;
      rem_btn  = load_off;
    end else if (in_data.green_press) begin
      mode_btn = MODE_ON;
      if (mode_r == MODE_OFF || mode_r == MODE_OFFDLY) begin
        rem_btn = load_step;
      end else begin
        rem_btn = sat_cnt(capped);
      end
    end

    // time running low
    mode_nxt = mode_btn;
    rem_nxt  = rem_btn;
    case (mode_btn)
      MODE_ON: begin
        if (W'(rem_btn) < W'(cfg.warn_ms)) mode_nxt = MODE_WARN;
      end
      MODE_WARN: begin
        if (rem_btn < COUNT_BITS'(WARN_END_MS)) begin
          mode_nxt = MODE_OFFDLY;
          rem_nxt  = load_off;
        end
      end
      MODE_OFFDLY: begin
        if (rem_btn < COUNT_BITS'(OFF_END_MS)) begin
          mode_nxt = MODE_OFF;
          rem_nxt  = '0;
        end
      end
      default: ;
    endcase

    s1_nxt.mode         = mode_nxt;
    s1_nxt.mode_changed = (mode_nxt != mode_r);
    s1_nxt.ms_clip      = (W'(rem_btn) > W'(SEC_CLIP_MS)) ? SEC_CLIP_MS
                                                          : REG_W'(W'(rem_btn));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_OFF;
      rem_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_fire || (s1_v_r && !dn_ready);
      if (in_fire) begin
        mode_r <= mode_nxt;
        rem_r  <= rem_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_valid = s1_v_r;
  assign s1_data  = s1_r;

endmodule

FILE: rtl/aort_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aort_out
// Milliseconds to seconds conversion and the result register.
// ----------------------------------------------------------------------------
module aort_out
  import aort_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      s1_valid,
  input  s1_t       s1_data,
  output logic      up_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int PROD_W = DIV_IN_W + RECIP_W;

  logic [DIV_IN_W-1:0] div_in;
  logic [PROD_W-1:0]   prod;
  logic                out_v_r;
  out_item_t           out_r, out_nxt;
  logic                load;

  assign up_ready = !out_v_r || out_ready;
  assign load     = s1_valid && up_ready;

  always_comb begin
    div_in = s1_data.ms_clip[REG_W-1:DIV_PRE_SHIFT];
    prod   = PROD_W'(div_in) * PROD_W'(RECIP_125);
    out_nxt.relay_on     = (s1_data.mode != MODE_OFF);
    out_nxt.mode         = s1_data.mode;
    out_nxt.seconds_left = prod[RECIP_SHIFT+SECS_W-1:RECIP_SHIFT];
    out_nxt.mode_changed = s1_data.mode_changed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= s1_valid || (out_v_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/auto_off_relay_timer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// auto_off_relay_timer_top
// Auto-off relay timer with warning and off delay, one item per ms tick.
// An accepted item is registered in the step stage, then in the output stage.
// Throughput: one item per cycle while out_ready holds (state update, then a
// constant-reciprocal multiply for the seconds display, one register stage each).
// Reset: registers to their defaults, mode off, count zero, pipeline empty.
// ----------------------------------------------------------------------------
module auto_off_relay_timer_top
  import aort_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  cfg_t cfg;
  logic s1_valid;
  s1_t  s1_data;
  logic dn_ready;

  aort_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  aort_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_ready (in_ready),
    .dn_ready (dn_ready),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  aort_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_data   (s1_data),
    .up_ready  (dn_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // accepted item reaches the middle stage
  a_accept_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted item lost before middle stage");

  // stalled middle stage keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && !dn_ready |=> s1_valid && $stable(s1_data))
    else $error("middle stage item dropped under stall");

  // off mode never shows time left
  a_off_no_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.mode == MODE_OFF |-> out_data.seconds_left == '0)
    else $error("time left shown while off");

endmodule
